@@ rtl/hwt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared constants, codes and types of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package hwt_pkg;

  localparam int unsigned NearBitsDef   = 8;
  localparam int unsigned LevelBitsDef  = 6;
  localparam int unsigned LevelCountDef = 4;
  localparam int unsigned PoolSizeDef   = 64;

  localparam logic [1:0] FuncSchedule = 2'd0;
  localparam logic [1:0] FuncCancelId = 2'd1;
  localparam logic [1:0] FuncCancelTg = 2'd2;
  localparam logic [1:0] FuncTick     = 2'd3;

  typedef enum logic [2:0] {
    KindSchedAck  = 3'd0,
    KindCancelAck = 3'd1,
    KindTargetAck = 3'd2,
    KindExpiry    = 3'd3,
    KindTickNone  = 3'd4
  } res_kind_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] tgt;
    logic [31:0] ses;
    logic [31:0] expiry;
    logic [15:0] pay;
  } rec_t;

endpackage

@@ rtl/hierarchical_timer_wheel_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top
// Timer pool on a hierarchical timing wheel: schedule, cancel by id,
// cancel by target and tick, all run by one sequencer over linked buckets.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   func, target, session, delay,
//                                                 cancel id, payload tag
//  out       output     out_valid_o / out_stall_i kind, id, target, session,
//                                                 payload, found, removed,
//                                                 pending, pool full, last
//
//  schedule files the new timer in its bucket before its result word; a cancel
//  walks buckets, reading each timer held and unlinking each timer removed;
//  a tick collects the timers due, cascades a bucket where the tick crosses a
//  level boundary and emits one expiry word per collected timer
//  after reset a clearing pass empties all buckets (512 by default) before
//  the first word is taken
//  one word in flight; a stalled output word holds the sequencer
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top #(
  parameter int unsigned NEAR_BITS   = hwt_pkg::NearBitsDef,
  parameter int unsigned LEVEL_BITS  = hwt_pkg::LevelBitsDef,
  parameter int unsigned LEVEL_COUNT = hwt_pkg::LevelCountDef,
  parameter int unsigned POOL_SIZE   = hwt_pkg::PoolSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        target_handle_i,
  input  logic [31:0]        session_id_i,
  input  logic signed [31:0] delay_ms_i,
  input  logic [31:0]        cancel_id_i,
  input  logic [15:0]        payload_tag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         result_kind_o,
  output logic [31:0]        tmr_id_o,
  output logic [31:0]        out_target_o,
  output logic [31:0]        out_session_o,
  output logic [15:0]        out_payload_o,
  output logic               found_o,
  output logic [6:0]         removed_count_o,
  output logic [6:0]         pending_count_o,
  output logic               pool_full_o,
  output logic               last_o
);
  import hwt_pkg::*;

  localparam int unsigned NearSize  = 1 << NEAR_BITS;
  localparam int unsigned LevelSize = 1 << LEVEL_BITS;
  localparam int unsigned Buckets   = NearSize + LEVEL_COUNT * LevelSize;
  localparam int unsigned BW = $clog2(Buckets);
  localparam int unsigned PW = $clog2(POOL_SIZE + 1);
  localparam int unsigned SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [PW-1:0] Nil = PW'(POOL_SIZE);
  localparam logic [BW-1:0] TopZero = BW'(NearSize + (LEVEL_COUNT - 1) * LevelSize);
  localparam logic [BW-1:0] LastBucket = BW'(Buckets - 1);

  localparam logic [4:0] S_CLR = 5'd0,  S_IDLE = 5'd1,  S_SCH_NX = 5'd2,
                         S_SCH_FH = 5'd3, S_F_RD = 5'd4, S_F_WR = 5'd5,
                         S_F_LK = 5'd6,  S_MV_RD = 5'd7, S_MV_DT = 5'd8,
                         S_MV_LP = 5'd9, S_MV_GO = 5'd10, S_MV_NX = 5'd11,
                         S_CO_RD = 5'd12, S_CO_DT = 5'd13, S_CO_LP = 5'd14,
                         S_CO_RL = 5'd15, S_ADV = 5'd16, S_EM_ST = 5'd17,
                         S_EM_Q = 5'd18, S_EM_R = 5'd19, S_EM_O = 5'd20,
                         S_CN_B = 5'd21, S_CN_H = 5'd22, S_CN_LP = 5'd23,
                         S_CN_CMP = 5'd24, S_CN_REL = 5'd25, S_ACK = 5'd26;

  // memories
  logic [2*PW-1:0] bk_mem [Buckets];
  logic [PW-1:0]   sn_mem [POOL_SIZE];
  rec_t            rec_mem [POOL_SIZE];
  logic [SW-1:0]   q_mem [POOL_SIZE];

  logic            bk_we, bk_re, sn_we, sn_re, rec_we, rec_re, q_we, q_re;
  logic [BW-1:0]   bk_wa, bk_ra;
  logic [2*PW-1:0] bk_wd, bk_rd_q;
  logic [SW-1:0]   sn_wa, sn_ra, sn_ra_q, rec_wa, rec_ra, q_wa, q_ra, q_wd, q_rd_q;
  logic [PW-1:0]   sn_wd, sn_rd_q, sn_val;
  logic [POOL_SIZE-1:0] sn_vld_q;
  logic            sn_rv_q;
  rec_t            rec_wd, rec_rd_q;

  always_ff @(posedge clk_i) begin
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    if (bk_re) bk_rd_q <= bk_mem[bk_ra];
    if (sn_we) sn_mem[sn_wa] <= sn_wd;
    if (sn_re) begin
      sn_rd_q <= sn_mem[sn_ra];
      sn_ra_q <= sn_ra;
    end
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) rec_rd_q <= rec_mem[rec_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_q <= q_mem[q_ra];
  end

  // free chain at reset: an unwritten link points to the following slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_vld_q <= '0;
      sn_rv_q  <= 1'b0;
    end else begin
      if (sn_we) sn_vld_q[sn_wa] <= 1'b1;
      if (sn_re) sn_rv_q <= sn_vld_q[sn_ra];
    end
  end

  assign sn_val = sn_rv_q ? sn_rd_q : (PW'(sn_ra_q) + PW'(1));

  // sequencer state
  logic [4:0]  st_q, st_d, ret_q, ret_d;
  logic [31:0] tick_q, tick_d, nid_q, nid_d, id_q, id_d, exp_q, exp_d;
  logic [31:0] tgt_q, tgt_d, ses_q, ses_d, cid_q, cid_d;
  logic [15:0] pay_q, pay_d;
  logic [1:0]  func_q, func_d;
  logic [PW-1:0] pend_q, pend_d, fh_q, fh_d, cnt_q, cnt_d, cur_q, cur_d;
  logic [PW-1:0] nxt_q, nxt_d, prev_q, prev_d, bh_q, bh_d, bt_q, bt_d;
  logic [PW-1:0] fs_q, fs_d, k_q, k_d, ei_q, ei_d;
  logic [BW-1:0] clr_q, clr_d, fb_q, fb_d, mvb_q, mvb_d, cb_q, cb_d;
  logic        full_q, full_d, col2_q, col2_d;

  // output word
  logic        ov_q, ov_d, ofree;
  res_kind_e   okind_q, okind_d;
  logic [31:0] oid_q, oid_d, otgt_q, otgt_d, oses_q, oses_d;
  logic [15:0] opay_q, opay_d;
  logic        ofound_q, ofound_d, ofull_q, ofull_d, olast_q, olast_d;
  logic [6:0]  orem_q, orem_d, opend_q, opend_d;

  // bucket for filing a timer
  logic [31:0]   fx;
  logic [BW-1:0] fb;
  logic          fdone;
  always_comb begin
    fx = exp_q ^ tick_q;
    fb = '0;
    fdone = 1'b0;
    if ((fx >> NEAR_BITS) == 32'd0) begin
      fb = BW'(exp_q[NEAR_BITS-1:0]);
    end else begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        if (!fdone && ((l == LEVEL_COUNT - 1) ||
            (({32'd0, fx} >> (NEAR_BITS + (l + 1) * LEVEL_BITS)) == 64'd0))) begin
          fdone = 1'b1;
          fb = BW'(NearSize + l * LevelSize) +
               BW'(LEVEL_BITS'({32'd0, exp_q} >> (NEAR_BITS + l * LEVEL_BITS)));
        end
      end
    end
  end

  // bucket to cascade on the next tick
  logic [31:0]         tn;
  logic [BW-1:0]       adv_b;
  logic                adv_mv, astop;
  logic [LEVEL_BITS-1:0] aidx;
  always_comb begin
    tn = tick_q + 32'd1;
    adv_b = '0;
    adv_mv = 1'b0;
    astop = 1'b0;
    aidx = '0;
    if (tn == 32'd0) begin
      adv_mv = 1'b1;
      adv_b = TopZero;
    end else begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        if (!astop) begin
          if (({32'd0, tn} & ((64'd1 << (NEAR_BITS + l * LEVEL_BITS)) - 64'd1)) != 64'd0) begin
            astop = 1'b1;
          end else begin
            aidx = LEVEL_BITS'({32'd0, tn} >> (NEAR_BITS + l * LEVEL_BITS));
            if (aidx != '0) begin
              adv_mv = 1'b1;
              adv_b = BW'(NearSize + l * LevelSize) + BW'(aidx);
              astop = 1'b1;
            end
          end
        end
      end
    end
  end

  logic [PW-1:0] bk_head, bk_tail, nh, nt;
  logic          match, elast;
  assign bk_head = bk_rd_q[2*PW-1:PW];
  assign bk_tail = bk_rd_q[PW-1:0];
  assign ofree = !ov_q || !out_stall_i;
  assign in_stall_o = (st_q != S_IDLE);

  always_comb begin
    st_d = st_q; ret_d = ret_q; tick_d = tick_q; nid_d = nid_q; id_d = id_q;
    exp_d = exp_q; tgt_d = tgt_q; ses_d = ses_q; cid_d = cid_q; pay_d = pay_q;
    func_d = func_q; pend_d = pend_q; fh_d = fh_q; cnt_d = cnt_q; cur_d = cur_q;
    nxt_d = nxt_q; prev_d = prev_q; bh_d = bh_q; bt_d = bt_q; fs_d = fs_q;
    k_d = k_q; ei_d = ei_q; clr_d = clr_q; fb_d = fb_q; mvb_d = mvb_q; cb_d = cb_q;
    full_d = full_q; col2_d = col2_q;
    ov_d = ov_q && out_stall_i;
    okind_d = okind_q; oid_d = oid_q; otgt_d = otgt_q; oses_d = oses_q;
    opay_d = opay_q; ofound_d = ofound_q; ofull_d = ofull_q; olast_d = olast_q;
    orem_d = orem_q; opend_d = opend_q;
    bk_we = 1'b0; bk_re = 1'b0; bk_wa = '0; bk_ra = '0; bk_wd = '0;
    sn_we = 1'b0; sn_re = 1'b0; sn_wa = '0; sn_ra = '0; sn_wd = '0;
    rec_we = 1'b0; rec_re = 1'b0; rec_wa = '0; rec_ra = '0; rec_wd = '0;
    q_we = 1'b0; q_re = 1'b0; q_wa = '0; q_ra = '0; q_wd = '0;
    nh = bh_q; nt = bt_q; match = 1'b0; elast = 1'b0;

    unique case (st_q)
      S_CLR: begin
        bk_we = 1'b1;
        bk_wa = clr_q;
        bk_wd = {Nil, Nil};
        if (clr_q == LastBucket) st_d = S_IDLE;
        else clr_d = clr_q + BW'(1);
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          tgt_d = target_handle_i;
          ses_d = session_id_i;
          cid_d = cancel_id_i;
          pay_d = payload_tag_i;
          exp_d = tick_q + (delay_ms_i[31] ? 32'd0 : delay_ms_i);
          cnt_d = '0;
          cb_d = '0;
          k_d = '0;
          col2_d = 1'b0;
          unique case (func_i)
            FuncSchedule: begin
              full_d = (fh_q == Nil);
              st_d = (fh_q == Nil) ? S_ACK : S_SCH_NX;
            end
            FuncCancelId, FuncCancelTg: st_d = S_CN_B;
            default: st_d = S_CO_RD;
          endcase
        end
      end
      S_SCH_NX: begin
        sn_re = 1'b1;
        sn_ra = fh_q[SW-1:0];
        rec_we = 1'b1;
        rec_wa = fh_q[SW-1:0];
        rec_wd = '{id: nid_q, tgt: tgt_q, ses: ses_q, expiry: exp_q, pay: pay_q};
        id_d = nid_q;
        nid_d = nid_q + 32'd1;
        fs_d = fh_q;
        pend_d = pend_q + PW'(1);
        st_d = S_SCH_FH;
      end
      S_SCH_FH: begin
        fh_d = sn_val;
        ret_d = S_ACK;
        st_d = S_F_RD;
      end
      S_F_RD: begin
        bk_re = 1'b1;
        bk_ra = fb;
        fb_d = fb;
        st_d = S_F_WR;
      end
      S_F_WR: begin
        sn_we = 1'b1;
        sn_wa = fs_q[SW-1:0];
        sn_wd = Nil;
        bk_we = 1'b1;
        bk_wa = fb_q;
        bk_wd = (bk_head == Nil) ? {fs_q, fs_q} : {bk_head, fs_q};
        bt_d = bk_tail;
        st_d = (bk_head == Nil) ? ret_q : S_F_LK;
      end
      S_F_LK: begin
        sn_we = 1'b1;
        sn_wa = bt_q[SW-1:0];
        sn_wd = fs_q;
        st_d = ret_q;
      end
      S_MV_RD: begin
        bk_re = 1'b1;
        bk_ra = mvb_q;
        st_d = S_MV_DT;
      end
      S_MV_DT: begin
        // detach the whole bucket before refiling
        cur_d = bk_head;
        bk_we = 1'b1;
        bk_wa = mvb_q;
        bk_wd = {Nil, Nil};
        st_d = S_MV_LP;
      end
      S_MV_LP: begin
        if (cur_q == Nil) begin
          st_d = S_CO_RD;
        end else begin
          sn_re = 1'b1;
          sn_ra = cur_q[SW-1:0];
          rec_re = 1'b1;
          rec_ra = cur_q[SW-1:0];
          st_d = S_MV_GO;
        end
      end
      S_MV_GO: begin
        nxt_d = sn_val;
        exp_d = rec_rd_q.expiry;
        fs_d = cur_q;
        ret_d = S_MV_NX;
        st_d = S_F_RD;
      end
      S_MV_NX: begin
        cur_d = nxt_q;
        st_d = S_MV_LP;
      end
      S_CO_RD: begin
        bk_re = 1'b1;
        bk_ra = BW'(tick_q[NEAR_BITS-1:0]);
        st_d = S_CO_DT;
      end
      S_CO_DT: begin
        cur_d = bk_head;
        bk_we = 1'b1;
        bk_wa = BW'(tick_q[NEAR_BITS-1:0]);
        bk_wd = {Nil, Nil};
        st_d = S_CO_LP;
      end
      S_CO_LP: begin
        if (cur_q == Nil) begin
          st_d = col2_q ? S_EM_ST : S_ADV;
        end else begin
          sn_re = 1'b1;
          sn_ra = cur_q[SW-1:0];
          st_d = S_CO_RL;
        end
      end
      S_CO_RL: begin
        // queue the expiry, hand the slot back to the free chain
        q_we = 1'b1;
        q_wa = k_q[SW-1:0];
        q_wd = cur_q[SW-1:0];
        k_d = k_q + PW'(1);
        sn_we = 1'b1;
        sn_wa = cur_q[SW-1:0];
        sn_wd = fh_q;
        fh_d = cur_q;
        if (pend_q != '0) pend_d = pend_q - PW'(1);
        cur_d = sn_val;
        st_d = S_CO_LP;
      end
      S_ADV: begin
        tick_d = tn;
        col2_d = 1'b1;
        mvb_d = adv_b;
        st_d = adv_mv ? S_MV_RD : S_CO_RD;
      end
      S_EM_ST: begin
        if (k_q == '0) begin
          if (ofree) begin
            ov_d = 1'b1;
            okind_d = KindTickNone;
            oid_d = '0; otgt_d = '0; oses_d = '0; opay_d = '0;
            ofound_d = 1'b0; ofull_d = 1'b0; orem_d = '0;
            opend_d = 7'(pend_q);
            olast_d = 1'b1;
            st_d = S_IDLE;
          end
        end else begin
          ei_d = '0;
          st_d = S_EM_Q;
        end
      end
      S_EM_Q: begin
        q_re = 1'b1;
        q_ra = ei_q[SW-1:0];
        st_d = S_EM_R;
      end
      S_EM_R: begin
        rec_re = 1'b1;
        rec_ra = q_rd_q;
        st_d = S_EM_O;
      end
      S_EM_O: begin
        if (ofree) begin
          elast = ((ei_q + PW'(1)) == k_q);
          ov_d = 1'b1;
          okind_d = KindExpiry;
          oid_d = rec_rd_q.id;
          otgt_d = rec_rd_q.tgt;
          oses_d = rec_rd_q.ses;
          opay_d = rec_rd_q.pay;
          ofound_d = 1'b0; ofull_d = 1'b0; orem_d = '0;
          opend_d = 7'(pend_q);
          olast_d = elast;
          ei_d = ei_q + PW'(1);
          st_d = elast ? S_IDLE : S_EM_Q;
        end
      end
      S_CN_B: begin
        bk_re = 1'b1;
        bk_ra = cb_q;
        st_d = S_CN_H;
      end
      S_CN_H: begin
        bh_d = bk_head;
        bt_d = bk_tail;
        prev_d = Nil;
        cur_d = bk_head;
        st_d = S_CN_LP;
      end
      S_CN_LP: begin
        if (cur_q == Nil) begin
          if (cb_q == LastBucket) begin
            st_d = S_ACK;
          end else begin
            cb_d = cb_q + BW'(1);
            st_d = S_CN_B;
          end
        end else begin
          sn_re = 1'b1;
          sn_ra = cur_q[SW-1:0];
          rec_re = 1'b1;
          rec_ra = cur_q[SW-1:0];
          st_d = S_CN_CMP;
        end
      end
      S_CN_CMP: begin
        match = (func_q == FuncCancelId) ? (rec_rd_q.id == cid_q) : (rec_rd_q.tgt == tgt_q);
        if (match) begin
          // unlink from the bucket list
          nh = (prev_q == Nil) ? sn_val : bh_q;
          nt = (bt_q == cur_q) ? prev_q : bt_q;
          if (prev_q != Nil) begin
            sn_we = 1'b1;
            sn_wa = prev_q[SW-1:0];
            sn_wd = sn_val;
          end
          bh_d = nh;
          bt_d = nt;
          bk_we = 1'b1;
          bk_wa = cb_q;
          bk_wd = {nh, nt};
          cnt_d = cnt_q + PW'(1);
          nxt_d = sn_val;
          st_d = S_CN_REL;
        end else begin
          prev_d = cur_q;
          cur_d = sn_val;
          st_d = S_CN_LP;
        end
      end
      S_CN_REL: begin
        sn_we = 1'b1;
        sn_wa = cur_q[SW-1:0];
        sn_wd = fh_q;
        fh_d = cur_q;
        if (pend_q != '0) pend_d = pend_q - PW'(1);
        cur_d = nxt_q;
        st_d = (func_q == FuncCancelId) ? S_ACK : S_CN_LP;
      end
      S_ACK: begin
        if (ofree) begin
          ov_d = 1'b1;
          unique case (func_q)
            FuncSchedule: okind_d = KindSchedAck;
            FuncCancelId: okind_d = KindCancelAck;
            default:      okind_d = KindTargetAck;
          endcase
          oid_d = (func_q == FuncSchedule && !full_q) ? id_q : 32'd0;
          otgt_d = '0; oses_d = '0; opay_d = '0;
          ofound_d = (func_q == FuncCancelId) && (cnt_q != '0);
          orem_d = (func_q == FuncCancelTg) ? 7'(cnt_q) : 7'd0;
          ofull_d = (func_q == FuncSchedule) && full_q;
          opend_d = 7'(pend_q);
          olast_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      clr_q <= '0;
      tick_q <= '0;
      nid_q <= '0;
      pend_q <= '0;
      fh_q <= '0;
      ov_q <= 1'b0;
      ret_q <= S_IDLE;
      col2_q <= 1'b0;
      func_q <= FuncSchedule;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      tick_q <= tick_d;
      nid_q <= nid_d;
      pend_q <= pend_d;
      fh_q <= fh_d;
      ov_q <= ov_d;
      ret_q <= ret_d;
      col2_q <= col2_d;
      func_q <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; exp_q <= exp_d; tgt_q <= tgt_d; ses_q <= ses_d; cid_q <= cid_d;
    pay_q <= pay_d; cnt_q <= cnt_d; cur_q <= cur_d; nxt_q <= nxt_d;
    prev_q <= prev_d; bh_q <= bh_d; bt_q <= bt_d; fs_q <= fs_d; k_q <= k_d;
    ei_q <= ei_d; fb_q <= fb_d; mvb_q <= mvb_d; cb_q <= cb_d; full_q <= full_d;
    okind_q <= okind_d; oid_q <= oid_d; otgt_q <= otgt_d; oses_q <= oses_d;
    opay_q <= opay_d; ofound_q <= ofound_d; ofull_q <= ofull_d;
    olast_q <= olast_d; orem_q <= orem_d; opend_q <= opend_d;
  end

  assign out_valid_o     = ov_q;
  assign result_kind_o   = okind_q;
  assign tmr_id_o        = oid_q;
  assign out_target_o    = otgt_q;
  assign out_session_o   = oses_q;
  assign out_payload_o   = opay_q;
  assign found_o         = ofound_q;
  assign removed_count_o = orem_q;
  assign pending_count_o = opend_q;
  assign pool_full_o     = ofull_q;
  assign last_o          = olast_q;

endmodule
